### sv/ipm_pkg.sv
// Shared constants, codes, types and helper functions of the indeterminate pattern matcher.
// No dependencies; every other file of the block imports this package.
package ipm_pkg;

   localparam int PATTERN_MAX  = 32;
   localparam int LETTER_COUNT = 16;

   // Fixed field widths of the request, response and configuration ports.
   localparam int SET_W      = 16;
   localparam int PINDEX_W   = 5;
   localparam int LENREG_W   = 6;
   localparam int POS_W      = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;

   // Derived widths.
   localparam int SYM_W = (LETTER_COUNT < SET_W) ? LETTER_COUNT : SET_W;
   localparam int IDX_W = $clog2(PATTERN_MAX);
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEN_REG = '0;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TEXT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ALN_READY,
      ALN_LOAD,
      ALN_SHIFT
   } aln_state_type;

   typedef struct packed {
      logic                written;
      logic [LENREG_W-1:0] len_reg;
   } csr_status_type;

   typedef struct packed {
      logic                shift_win;
      logic                clear_win;
      logic                load_pat;
      logic [PINDEX_W-1:0] load_index;
      logic [SYM_W-1:0]    load_set;
      logic                realign_load;
      logic                realign_shift;
      logic [LEN_W-1:0]    len_eff;
   } cell_ctl_type;

   // A length of zero acts as one; a length above the cell count acts as the cell count.
   function automatic logic [LEN_W-1:0] clamp_length(input logic [LENREG_W-1:0] value);
      logic [LEN_W-1:0] result;
      if (value == '0) begin
         result = LEN_W'(1);
      end else if (32'(value) > 32'(PATTERN_MAX)) begin
         result = LEN_W'(PATTERN_MAX);
      end else begin
         result = LEN_W'(value);
      end
      return result;
   endfunction

endpackage

### sv/indeterminate_pattern_matcher.sv
// Top level of the indeterminate pattern matcher: cell chain, text counters and response register.
// Depends on ipm_pkg, ipm_cell and ipm_csr.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  op, symbol_set, pattern_index, last_of_text
//   rsp_      out         rsp_valid / rsp_stall  match_found, match_start, occurrence_count
//   csr_      in/out      psel, penable, pready  paddr, pwdata, prdata
//
// Each request, load or text symbol, yields one response, registered in the next cycle;
// requests follow each other in every cycle while the response register is free or drained.
// A write of the pattern length realigns the chain: the aligned slots take the pattern, then it
// steps down PATTERN_MAX - length cells, one cell step a cycle, during which no request is taken.
// Synchronous active-high reset empties the window, clears the text position and count, and sets
// the length to one. A stalled response holds the register and the request side stalls with it.
module indeterminate_pattern_matcher (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic [ipm_pkg::SET_W-1:0]        req_symbol_set,
   input  logic [ipm_pkg::PINDEX_W-1:0]     req_pattern_index,
   input  logic                             req_last_of_text,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_match_found,
   output logic [ipm_pkg::POS_W-1:0]        rsp_match_start,
   output logic [ipm_pkg::POS_W-1:0]        rsp_occurrence_count,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ipm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ipm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ipm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import ipm_pkg::*;

   csr_status_type   status;
   cell_ctl_type     ctl;
   logic [LEN_W-1:0] len_eff;

   // Chain wiring: the window moves towards higher cells, the aligned pattern towards cell 0.
   logic [SYM_W-1:0]       win_out [PATTERN_MAX];
   logic [SYM_W-1:0]       aln_out [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] hit;
   logic [SYM_W-1:0]       sym;

   // Request side.
   logic accept;
   logic take_text;
   logic take_load;

   // Text state.
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] total_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] total_in;
   logic             full;
   logic             found;
   logic [POS_W-1:0] start;
   logic [POS_W-1:0] total_next;

   // Response register.
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_found_ff;
   logic [POS_W-1:0] rsp_start_ff;
   logic [POS_W-1:0] rsp_count_ff;

   // Realignment sequencer.
   aln_state_type    aln_state_ff;
   aln_state_type    aln_state_in;
   logic [IDX_W-1:0] aln_count_ff;
   logic [IDX_W-1:0] aln_count_in;
   logic             realign_load;
   logic             realign_shift;

   ipm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .status      (status)
   );

   assign len_eff = clamp_length(status.len_reg);
   assign sym     = req_symbol_set[SYM_W-1:0];

   // A request waits while the chain realigns or while the response register stays full.
   assign req_stall = (aln_state_ff != ALN_READY) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign take_text = accept && (req_op == OP_TEXT);
   // An index beyond the chain is dropped; the response still follows.
   assign take_load = accept && (req_op == OP_LOAD) &&
                      (32'(req_pattern_index) < 32'(PATTERN_MAX));

   // Realignment: copy the reversed pattern into the aligned slots, then step it down
   // PATTERN_MAX - length places so that each cell meets its own pattern position.
   always_comb begin
      aln_state_in = aln_state_ff;
      unique case (aln_state_ff)
         ALN_READY: begin
            if (status.written) begin
               aln_state_in = ALN_LOAD;
            end
         end
         ALN_LOAD: begin
            if (status.written) begin
               aln_state_in = ALN_LOAD;
            end else if (IDX_W'(LEN_W'(PATTERN_MAX) - len_eff) == '0) begin
               aln_state_in = ALN_READY;
            end else begin
               aln_state_in = ALN_SHIFT;
            end
         end
         ALN_SHIFT: begin
            if (status.written) begin
               aln_state_in = ALN_LOAD;
            end else if (aln_count_ff == IDX_W'(1)) begin
               aln_state_in = ALN_READY;
            end
         end
         default: aln_state_in = ALN_READY;
      endcase
   end

   always_comb begin
      realign_load  = 1'b0;
      realign_shift = 1'b0;
      aln_count_in  = aln_count_ff;
      unique case (aln_state_ff)
         ALN_READY: begin
         end
         ALN_LOAD: begin
            realign_load = 1'b1;
            aln_count_in = IDX_W'(LEN_W'(PATTERN_MAX) - len_eff);
         end
         ALN_SHIFT: begin
            realign_shift = 1'b1;
            aln_count_in  = aln_count_ff - IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aln_state_ff <= ALN_READY;
         aln_count_ff <= '0;
      end else begin
         aln_state_ff <= aln_state_in;
         aln_count_ff <= aln_count_in;
      end
   end

   assign ctl.shift_win     = take_text;
   assign ctl.clear_win     = take_text && req_last_of_text;
   assign ctl.load_pat      = take_load;
   assign ctl.load_index    = req_pattern_index;
   assign ctl.load_set      = sym;
   assign ctl.realign_load  = realign_load;
   assign ctl.realign_shift = realign_shift;
   assign ctl.len_eff       = len_eff;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      logic [SYM_W-1:0] win_in;
      logic [SYM_W-1:0] aln_in;

      if (j == 0) begin : g_head
         assign win_in = sym;
      end else begin : g_body
         assign win_in = win_out[j-1];
      end

      if (j == PATTERN_MAX - 1) begin : g_tail
         assign aln_in = '0;
      end else begin : g_inner
         assign aln_in = aln_out[j+1];
      end

      ipm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(j)),
         .ctl      (ctl),
         .win_in   (win_in),
         .aln_in   (aln_in),
         .win_out  (win_out[j]),
         .aln_out  (aln_out[j]),
         .hit      (hit[j])
      );
   end

   // The window is full once the text position reaches length - 1; the start position is
   // reported from then on, whether or not the pattern matches.
   assign full       = pos_ff >= (POS_W'(len_eff) - POS_W'(1));
   assign start      = full ? (pos_ff - (POS_W'(len_eff) - POS_W'(1))) : '0;
   assign found      = full && (&hit);
   assign total_next = (found && (total_ff != POS_MAX)) ? (total_ff + POS_W'(1)) : total_ff;

   always_comb begin
      pos_in   = pos_ff;
      total_in = total_ff;
      if (take_text) begin
         if (req_last_of_text) begin
            pos_in   = '0;
            total_in = '0;
         end else begin
            pos_in   = (pos_ff != POS_MAX) ? (pos_ff + POS_W'(1)) : pos_ff;
            total_in = total_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         total_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
      end
   end

   // Response register: filled by every accepted request, emptied when the far side takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_text) begin
         rsp_found_ff <= found;
         rsp_start_ff <= start;
         rsp_count_ff <= total_next;
      end else if (accept) begin
         rsp_found_ff <= 1'b0;
         rsp_start_ff <= '0;
         rsp_count_ff <= total_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_match_found      = rsp_found_ff;
   assign rsp_match_start      = rsp_start_ff;
   assign rsp_occurrence_count = rsp_count_ff;

endmodule

### sv/ipm_cell.sv
// One cell of the matcher chain: a window slot, a pattern slot and an aligned pattern slot.
// Depends on ipm_pkg for widths and the control struct.
module ipm_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ipm_pkg::IDX_W-1:0]   cell_idx,
   input  ipm_pkg::cell_ctl_type       ctl,
   input  logic [ipm_pkg::SYM_W-1:0]   win_in,
   input  logic [ipm_pkg::SYM_W-1:0]   aln_in,
   output logic [ipm_pkg::SYM_W-1:0]   win_out,
   output logic [ipm_pkg::SYM_W-1:0]   aln_out,
   output logic                        hit
);
   import ipm_pkg::*;

   logic [SYM_W-1:0] win_ff;
   logic [SYM_W-1:0] pat_ff;
   logic [SYM_W-1:0] aln_ff;
   logic             pat_wr;
   logic             aln_wr;
   logic             in_use;

   // The pattern slot holds the pattern in reversed order; the aligned slot holds the
   // pattern position that meets this window slot under the current length.
   assign pat_wr = ctl.load_pat &&
                   (32'(ctl.load_index) == 32'(PATTERN_MAX) - 32'd1 - 32'(cell_idx));
   assign aln_wr = ctl.load_pat &&
                   (32'(ctl.load_index) + 32'(cell_idx) == 32'(ctl.len_eff) - 32'd1);
   assign in_use = 32'(cell_idx) < 32'(ctl.len_eff);

   // The compare sees the symbol that this slot takes with the current shift.
   assign hit = !in_use || ((aln_ff & win_in) != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (ctl.clear_win) begin
         win_ff <= '0;
      end else if (ctl.shift_win) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pat_wr) begin
         pat_ff <= ctl.load_set;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.realign_load) begin
         aln_ff <= pat_ff;
      end else if (ctl.realign_shift) begin
         aln_ff <= aln_in;
      end else if (aln_wr) begin
         aln_ff <= ctl.load_set;
      end
   end

   assign win_out = win_ff;
   assign aln_out = aln_ff;

endmodule

### sv/ipm_csr.sv
// Configuration register file of the matcher: the pattern length register and its read path.
// Depends on ipm_pkg for widths, the register index and the status struct.
module ipm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ipm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ipm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ipm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output ipm_pkg::csr_status_type          status
);
   import ipm_pkg::*;

   logic [LENREG_W-1:0]    len_reg_ff;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic                   wr_len;

   assign reg_index = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_len    = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (reg_index == CSR_LEN_REG);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_reg_ff <= LENREG_W'(1);
      end else if (wr_len) begin
         len_reg_ff <= csr_pwdata[LENREG_W-1:0];
      end
   end

   always_comb begin
      unique case (reg_index)
         CSR_LEN_REG: csr_prdata = CSR_DATA_W'(len_reg_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign csr_pready     = 1'b1;
   assign status.written = wr_len;
   assign status.len_reg = len_reg_ff;

endmodule

### tb/ipm_match_checker.sv
`timescale 1ns / 1ps
// Response checker of the indeterminate pattern matcher: follows the request, response and register
// ports, keeps its own pattern, window and counters, and compares every response in order.
// Depends on ipm_pkg.
module ipm_match_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_op,
   input  logic [ipm_pkg::SET_W-1:0]      req_symbol_set,
   input  logic [ipm_pkg::PINDEX_W-1:0]   req_pattern_index,
   input  logic                           req_last_of_text,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_match_found,
   input  logic [ipm_pkg::POS_W-1:0]      rsp_match_start,
   input  logic [ipm_pkg::POS_W-1:0]      rsp_occurrence_count,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ipm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ipm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [ipm_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             pending
);
   import ipm_pkg::*;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] count;
   } match_result_type;

   logic [SYM_W-1:0]    pattern_sets [PATTERN_MAX];
   logic [SYM_W-1:0]    window_sets  [PATTERN_MAX];
   logic [POS_W-1:0]    next_position;
   logic [POS_W-1:0]    match_count;
   logic [LENREG_W-1:0] length_reg;
   match_result_type    expected_matches [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what, input logic [POS_W-1:0] want,
                                  input logic [POS_W-1:0] got);
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      fail_count++;
   endtask

   task automatic clear_text();
      for (int k = 0; k < PATTERN_MAX; k++) window_sets[k] = '0;
      next_position = '0;
      match_count   = '0;
   endtask

   // Applies one request to the local state and works out the response it should cause.
   task automatic predict_match_result(input logic op, input logic [SET_W-1:0] set_in,
                                       input logic [PINDEX_W-1:0] index, input logic last,
                                       output match_result_type res);
      int               span;
      logic [SYM_W-1:0] sym;
      sym = set_in[SYM_W-1:0];
      res = '0;
      if (op_type'(op) == OP_LOAD) begin
         if (int'(index) < PATTERN_MAX) pattern_sets[index] = sym;
         res.count = match_count;
      end else begin
         if (length_reg == '0) span = 1;
         else if (int'(length_reg) > PATTERN_MAX) span = PATTERN_MAX;
         else span = int'(length_reg);
         for (int k = PATTERN_MAX - 1; k > 0; k--) window_sets[k] = window_sets[k-1];
         window_sets[0] = sym;
         if (next_position >= POS_W'(span - 1)) begin
            res.start = next_position - POS_W'(span - 1);
            res.found = 1'b1;
            // The oldest symbol of the window lines up with pattern position zero.
            for (int j = 0; j < span; j++) begin
               if ((pattern_sets[span-1-j] & window_sets[j]) == '0) res.found = 1'b0;
            end
         end
         if (res.found && match_count != '1) match_count++;
         if (next_position != '1) next_position++;
         res.count = match_count;
         if (last) clear_text();
      end
   endtask

   always @(posedge clock) begin : watch
      match_result_type res;
      match_result_type want;
      if (reset) begin
         clear_text();
         length_reg = LENREG_W'(1);
         expected_matches.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_LEN_REG) begin
            if (csr_pwrite) begin
               length_reg = csr_pwdata[LENREG_W-1:0];
            end else if (csr_prdata[LENREG_W-1:0] !== length_reg) begin
               report_mismatch("length register read", POS_W'(length_reg),
                               POS_W'(csr_prdata[LENREG_W-1:0]));
            end
         end
         if (req_valid && !req_stall) begin
            predict_match_result(req_op, req_symbol_set, req_pattern_index, req_last_of_text, res);
            expected_matches = {expected_matches, res};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               report_mismatch("response with no request waiting, count", '0,
                               rsp_occurrence_count);
            end else begin
               want = expected_matches.pop_front();
               if (rsp_match_found !== want.found)
                  report_mismatch("match_found", POS_W'(want.found), POS_W'(rsp_match_found));
               if (rsp_match_start !== want.start)
                  report_mismatch("match_start", want.start, rsp_match_start);
               if (rsp_occurrence_count !== want.count)
                  report_mismatch("occurrence_count", want.count, rsp_occurrence_count);
            end
         end
      end
      pending = expected_matches.size();
   end

endmodule

### tb/indeterminate_pattern_matcher_tb.sv
`timescale 1ns / 1ps
// Top of the indeterminate pattern matcher testbench: clock, reset, request and register stimulus,
// response stalling and the verdict. Depends on ipm_pkg, the block and ipm_match_checker.
module indeterminate_pattern_matcher_tb;
   import ipm_pkg::*;

   localparam int RESET_CYCLES  = 6;
   localparam int ITEM_TARGET   = 450;
   localparam int MAX_WAIT      = 18;
   localparam int LONG_HOLD     = 120;
   localparam int SETTLE_CYCLES = 10;
   // Well above the slowest correct run, which the sender gaps, the response stalls, a realignment
   // per length write and the long hold make up.
   localparam int CYCLE_LIMIT   = 300000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_op = 1'b0;
   logic [SET_W-1:0]      req_symbol_set = '0;
   logic [PINDEX_W-1:0]   req_pattern_index = '0;
   logic                  req_last_of_text = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_match_found;
   logic [POS_W-1:0]      rsp_match_start;
   logic [POS_W-1:0]      rsp_occurrence_count;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending;
   int cycle_count = 0;

   // Shared between the stimulus and the response side. When steady is set neither side idles,
   // so that requests and responses run back to back. Each increment of hold_requests asks the
   // response side for one long stall.
   logic steady = 1'b0;
   int   hold_requests = 0;

   // The stimulus keeps its own note of what the pattern holds, so that it can build text that
   // lines up with it and never lets the block read a position that has not been loaded.
   logic [SET_W-1:0]       pattern_copy [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] pattern_written = '0;
   logic [LENREG_W-1:0]    length_now = LENREG_W'(1);
   int                     items_sent = 0;

   indeterminate_pattern_matcher dut (.*);

   ipm_match_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake must not keep the simulation alive for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response side. Before each response it stalls for a random number of cycles, then lowers
   // stall and waits for the response to be taken. When the stimulus asks for a long hold it
   // keeps stall high for a long hold, counted here, so that the block backs up.
   initial begin : drain
      int holds_done;
      int pause;
      holds_done = 0;
      wait (!reset);
      forever begin
         if (holds_done != hold_requests) begin
            holds_done++;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
         pause = steady ? 0 : $urandom_range(0, MAX_WAIT);
         repeat (pause) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offers one request after a random gap and holds it until the block takes it. The task
   // returns at the accepting edge with valid still high, so that a following request can
   // replace it at the next falling edge without a dip in valid.
   task automatic send_request(input op_type op, input logic [SET_W-1:0] set_in,
                               input logic [PINDEX_W-1:0] index, input logic last);
      int gap;
      gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_op            <= op;
      req_symbol_set    <= set_in;
      req_pattern_index <= index;
      req_last_of_text  <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (op == OP_LOAD && int'(index) < PATTERN_MAX) begin
         pattern_copy[index]    = set_in;
         pattern_written[index] = 1'b1;
      end
   endtask

   // The pattern index of a text request and the end-of-text flag of a load do nothing, so
   // they are given random values.
   task automatic send_load(input int index, input logic [SET_W-1:0] set_in);
      send_request(OP_LOAD, set_in, PINDEX_W'(index), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_text(input logic [SET_W-1:0] set_in, input logic last);
      send_request(OP_TEXT, set_in, PINDEX_W'($urandom), last);
   endtask

   // Drops valid and waits until every response that is owed has been taken.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Writes the pattern length while the block is idle, then reads it back; the checker
   // compares the value read. After the write the block realigns its chain and holds off
   // requests for a while, which the request handshake absorbs.
   task automatic write_length(input logic [LENREG_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_LEN_REG, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      length_now = value;
   endtask

   function automatic int span_of(input logic [LENREG_W-1:0] value);
      if (value == '0) return 1;
      if (int'(value) > PATTERN_MAX) return PATTERN_MAX;
      return int'(value);
   endfunction

   // Pattern sets are mostly sparse, so that text which does not line up with the pattern
   // usually fails to match.
   function automatic logic [SET_W-1:0] random_pattern_set();
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return SET_W'($urandom);
         2, 3:    return (SET_W'(1) << $urandom_range(0, SET_W - 1)) |
                         (SET_W'(1) << $urandom_range(0, SET_W - 1));
         default: return SET_W'(1) << $urandom_range(0, SET_W - 1);
      endcase
   endfunction

   // A text symbol that shares at least one letter with the given pattern set, sometimes with
   // extra letters thrown in; for an empty set it is any random symbol.
   function automatic logic [SET_W-1:0] matching_symbol(input logic [SET_W-1:0] want);
      int bit_no;
      if (want == '0) return SET_W'($urandom);
      do bit_no = $urandom_range(0, SET_W - 1); while (!want[bit_no]);
      return (SET_W'(1) << bit_no) | (($urandom_range(0, 1) == 1) ? SET_W'($urandom) : '0);
   endfunction

   function automatic logic [SET_W-1:0] noise_symbol();
      case ($urandom_range(0, 7))
         0:       return '0;
         1, 2:    return SET_W'($urandom);
         default: return SET_W'(1) << $urandom_range(0, SET_W - 1);
      endcase
   endfunction

   // One phase of the random part: possibly a new length (the first phases take the extremes),
   // loads for any position the length now reaches that was never written, a few random
   // reloads, then text made mostly of whole occurrences of the pattern with noise between.
   // A text is not ended at a phase boundary, so a length change often lands mid-text.
   task automatic run_phase(input int phase_no);
      logic [LENREG_W-1:0] value;
      int                  span;
      int                  texts;
      case (phase_no)
         0:       value = LENREG_W'(PATTERN_MAX);
         1:       value = '1;
         2:       value = '0;
         3:       value = LENREG_W'(1);
         default: value = ($urandom_range(0, 5) == 0) ? LENREG_W'($urandom)
                                                      : LENREG_W'($urandom_range(2, 10));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      if (phase_no < 4 || $urandom_range(0, 2) != 0) write_length(value);
      span = span_of(length_now);
      for (int k = 0; k < span; k++) begin
         if (!pattern_written[k]) send_load(k, random_pattern_set());
      end
      repeat ($urandom_range(0, 3)) send_load($urandom_range(0, PATTERN_MAX - 1),
                                              random_pattern_set());
      // The long hold falls where the length is one, so the sender keeps offering requests
      // throughout and the block fills up and stalls its input.
      if (phase_no == 2) begin
         steady = 1'b0;
         hold_requests++;
      end
      texts = $urandom_range(15, 40);
      while (texts > 0) begin
         if ($urandom_range(0, 9) < 6) begin
            for (int k = 0; k < span; k++) begin
               send_text(matching_symbol(pattern_copy[k]), $urandom_range(0, 29) == 0);
               texts--;
            end
         end else begin
            send_text(noise_symbol(), $urandom_range(0, 29) == 0);
            texts--;
         end
      end
      // Once the sender also pauses on its own until every response has come back.
      if (phase_no == 5) wait_idle();
   endtask

   initial begin : stimulus
      int phase_no;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Length one after reset; the end-of-text flag on a load is ignored.
      send_load(0, 16'h0001);
      send_text(16'h0001, 1'b0);
      send_text(16'h0000, 1'b0);          // empty set never matches
      send_text(16'hFFFE, 1'b0);
      send_text(16'hFFFF, 1'b1);          // match, then the text is cleared
      write_length('0);                   // zero acts as one
      send_text(16'h0001, 1'b1);
      write_length(LENREG_W'(3));
      send_load(1, 16'h8000);
      send_load(2, 16'h0000);             // an empty pattern position blocks every match
      send_text(16'h0001, 1'b0);          // window not yet full
      send_text(16'h8000, 1'b0);
      send_text(16'hFFFF, 1'b0);
      send_load(2, 16'h0F00);
      send_text(16'h0001, 1'b0);
      send_text(16'h8000, 1'b0);
      send_text(16'h0100, 1'b0);          // whole pattern lines up
      write_length(LENREG_W'(2));         // shorter length takes effect on the current window
      send_text(16'h8000, 1'b0);
      send_text(16'h0001, 1'b0);
      send_text(16'h8000, 1'b0);
      send_load(PATTERN_MAX - 1, 16'hFFFF);
      send_load(16, 16'h5555);
      send_text(16'h7FFF, 1'b1);

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         run_phase(phase_no);
         phase_no++;
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
